### design/chained_hash_table_engine_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the chained hash table engine
// Clocked, reset-qualified property wrappers shared by the checker.
// ---------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_ENGINE_MACROS_SVH
`define CHAINED_HASH_TABLE_ENGINE_MACROS_SVH

// Same-cycle implication on clk, held off while rst_n is low.
`define CHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk, held off while rst_n is low.
`define CHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/cht_pkg.sv
// ---------------------------------------------------------------------------
// cht_pkg
// Sizes, codes and row types of the chained hash table engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cht_pkg;

  localparam int BUCKETS    = 16;  // power of two: bucket is the low key bits
  localparam int WAYS       = 4;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  localparam int BUCKET_BITS = $clog2(BUCKETS);
  localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam int MODE_W  = 2;
  localparam int FIELD_W = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_FIND   = 2'd1,
    MODE_ERASE  = 2'd2
  } mode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LOOK = 1'b1
  } state_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic                hit;
    logic [WAY_BITS-1:0] hit_way;
    logic                has_free;
    logic [WAY_BITS-1:0] free_way;
  } match_t;

endpackage

### design/cht_if.sv
// ---------------------------------------------------------------------------
// cht_in_if / cht_out_if
// Valid/ready channels for operation beats and result beats.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cht_in_if;
  logic                         valid;
  logic                         ready;
  logic [cht_pkg::MODE_W-1:0]   mode;
  logic [cht_pkg::FIELD_W-1:0]  key;
  logic [cht_pkg::FIELD_W-1:0]  value;

  modport source (output valid, output mode, output key, output value, input ready);
  modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

interface cht_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [cht_pkg::FIELD_W-1:0]  read_value;
  logic                         dropped;

  modport source (output valid, output hit, output read_value, output dropped, input ready);
  modport sink   (input valid, input hit, input read_value, input dropped, output ready);
endinterface

### design/chained_hash_table_engine.sv
// ---------------------------------------------------------------------------
// chained_hash_table_engine
// Operation path: bucket row read into the RAM's registered read port, then
//   compare and write-back into the output register.
// One operation at a time, set by the read-then-write of the bucket row
//   RAM: a new beat waits for the write-back; a held result stalls it.
// Reset: rst_n clears the way valid flags (table empty) and the handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module chained_hash_table_engine (
  input  logic           clk,
  input  logic           rst_n,
  cht_in_if.sink         in_ch,
  cht_out_if.source      out_ch
);

  cht_pkg::state_t state_r, state_nxt;

  logic [cht_pkg::MODE_W-1:0]      mode_r;
  logic [cht_pkg::KEY_BITS-1:0]    key_r;
  logic [cht_pkg::VALUE_BITS-1:0]  value_r;
  logic [cht_pkg::BUCKET_BITS-1:0] bucket_r;

  logic [cht_pkg::BUCKETS-1:0][cht_pkg::WAYS-1:0] valid_r, valid_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_hit_r, out_hit_nxt;
  logic [cht_pkg::FIELD_W-1:0]   out_read_value_r, out_read_value_nxt;
  logic                          out_dropped_r, out_dropped_nxt;

  logic                          accept;
  logic                          fire;
  logic                          rd_en;
  logic                          wr_en;
  logic [cht_pkg::KEY_BITS-1:0]  in_key;
  cht_pkg::row_t                 rd_row;
  cht_pkg::row_t                 wr_row;
  cht_pkg::match_t               match;

  assign in_key = cht_pkg::KEY_BITS'(in_ch.key);

  // ---- state machine: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cht_pkg::ST_IDLE: if (in_ch.valid) state_nxt = cht_pkg::ST_LOOK;
      cht_pkg::ST_LOOK: if (!out_valid_r || out_ch.ready) state_nxt = cht_pkg::ST_IDLE;
      default:          state_nxt = cht_pkg::ST_IDLE;
    endcase
  end

  // ---- state machine: outputs
  always_comb begin
    in_ch.ready = 1'b0;
    fire        = 1'b0;
    unique case (state_r)
      // refuse beats while reset is held
      cht_pkg::ST_IDLE: in_ch.ready = rst_n;
      cht_pkg::ST_LOOK: fire = !out_valid_r || out_ch.ready;
      default:          in_ch.ready = 1'b0;
    endcase
  end

  assign accept = in_ch.valid && in_ch.ready;
  assign rd_en  = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cht_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---- capture the operation beat
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= in_ch.mode;
      key_r    <= in_key;
      value_r  <= cht_pkg::VALUE_BITS'(in_ch.value);
      bucket_r <= in_key[cht_pkg::BUCKET_BITS-1:0];
    end
  end

  cht_row_ram #(
    .WIDTH ($bits(cht_pkg::row_t)),
    .DEPTH (cht_pkg::BUCKETS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (bucket_r),
    .wr_data (wr_row),
    .rd_en   (rd_en),
    .rd_addr (in_key[cht_pkg::BUCKET_BITS-1:0]),
    .rd_data (rd_row)
  );

  cht_way_match u_way_match (
    .row   (rd_row),
    .valid (valid_r[bucket_r]),
    .key   (key_r),
    .match (match)
  );

  // ---- modify: row write-back, valid flags, result
  always_comb begin
    valid_nxt          = valid_r;
    wr_en              = 1'b0;
    wr_row             = rd_row;
    out_valid_nxt      = out_valid_r && !out_ch.ready;
    out_hit_nxt        = out_hit_r;
    out_read_value_nxt = out_read_value_r;
    out_dropped_nxt    = out_dropped_r;
    if (fire) begin
      out_valid_nxt      = 1'b1;
      out_hit_nxt        = 1'b0;
      out_read_value_nxt = '0;
      out_dropped_nxt    = 1'b0;
      unique case (mode_r)
        cht_pkg::MODE_INSERT: begin
          if (match.hit) begin
            out_hit_nxt                 = 1'b1;
            wr_en                       = 1'b1;
            wr_row[match.hit_way].value = value_r;
          end else if (match.has_free) begin
            wr_en                                   = 1'b1;
            wr_row[match.free_way].key              = key_r;
            wr_row[match.free_way].value            = value_r;
            valid_nxt[bucket_r][match.free_way]     = 1'b1;
          end else begin
            out_dropped_nxt = 1'b1;
          end
        end
        cht_pkg::MODE_FIND: begin
          if (match.hit) begin
            out_hit_nxt        = 1'b1;
            out_read_value_nxt = cht_pkg::FIELD_W'(rd_row[match.hit_way].value);
          end
        end
        cht_pkg::MODE_ERASE: begin
          if (match.hit) begin
            out_hit_nxt                        = 1'b1;
            valid_nxt[bucket_r][match.hit_way] = 1'b0;
          end
        end
        default: begin
          // unused code: no operation, all-zero result
          out_hit_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r        <= out_hit_nxt;
    out_read_value_r <= out_read_value_nxt;
    out_dropped_r    <= out_dropped_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.read_value = out_read_value_r;
  assign out_ch.dropped    = out_dropped_r;

endmodule

### design/cht_row_ram.sv
// ---------------------------------------------------------------------------
// cht_row_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cht_row_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/cht_way_match.sv
// ---------------------------------------------------------------------------
// cht_way_match
// Parallel compare of one bucket row: lowest matching way, lowest free way.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cht_way_match (
  input  cht_pkg::row_t                 row,
  input  logic [cht_pkg::WAYS-1:0]      valid,
  input  logic [cht_pkg::KEY_BITS-1:0]  key,
  output cht_pkg::match_t               match
);

  always_comb begin
    match = '0;
    // scan high to low so the lowest way wins
    for (int w = cht_pkg::WAYS - 1; w >= 0; w--) begin
      if (valid[w] && row[w].key == key) begin
        match.hit     = 1'b1;
        match.hit_way = cht_pkg::WAY_BITS'(w);
      end
      if (!valid[w]) begin
        match.has_free = 1'b1;
        match.free_way = cht_pkg::WAY_BITS'(w);
      end
    end
  end

endmodule

### design/cht_checker.sv
// ---------------------------------------------------------------------------
// cht_checker
// Port-level checks of the chained hash table engine, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "chained_hash_table_engine_macros.svh"

module cht_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_hit,
  input logic [cht_pkg::FIELD_W-1:0] out_read_value,
  input logic                        out_dropped
);

  // hold a stalled result beat
  `CHT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_hit) && $stable(out_read_value) && $stable(out_dropped), "result beat changed while stalled")

  // one operation in flight: no accept right after an accept
  `CHT_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "operation accepted back to back")

  // a drop never reports a hit
  `CHT_ASSERT_NOW(a_drop_no_hit, out_valid && out_dropped, !out_hit, "dropped insert flagged as hit")

  // a nonzero read value only comes with a hit
  `CHT_ASSERT_NOW(a_value_needs_hit, out_valid && out_read_value != '0, out_hit && !out_dropped, "read value without hit")

endmodule

bind chained_hash_table_engine cht_checker u_cht_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_hit        (out_ch.hit),
  .out_read_value (out_ch.read_value),
  .out_dropped    (out_ch.dropped)
);
